>>> src/meaf_pkg.sv
// Shared widths, register indexes, flag bundle and fill-level table for the edge antialias filter.
package meaf_pkg;

   localparam int PIX_W       = 8;
   localparam int ROW_W       = 12;
   localparam int COL_OUT_W   = 9;
   localparam int FW_W        = 10;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int DEF_MAX_WIDTH = 512;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [FW_W-1:0]  FW_RESET   = 10'd320;
   localparam logic [ROW_W-1:0] FH_RESET   = 12'd240;
   localparam logic [PIX_W-1:0] FULL_LEVEL = 8'hFF;

   // Per-beat classification made by the front end.
   typedef struct packed {
      logic has_up;     // a row above exists, so that row's pixel goes out now
      logic last_row;   // arriving pixel is in the final row and goes out too
      logic end_frame;  // arriving pixel closes the frame
      logic filt_ok;    // pixel of the row above is interior
      logic self_wrap;  // one-column frame: next column is this column
   } meaf_flags_type;

   // count * 255 / 4
   function automatic logic [PIX_W-1:0] fill_level(input logic [2:0] cnt);
      logic [PIX_W-1:0] lvl;
      case (cnt)
         3'd0: lvl = 8'd0;
         3'd1: lvl = 8'd63;
         3'd2: lvl = 8'd127;
         3'd3: lvl = 8'd191;
         3'd4: lvl = 8'd255;
         default: lvl = 8'd255;
      endcase
      return lvl;
   endfunction

endpackage

>>> src/meaf_channels.sv
// Channel interfaces: pixel input, result output and register write port.
interface meaf_req_if import meaf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

interface meaf_rsp_if import meaf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ROW_W-1:0]     out_row;
   logic [COL_OUT_W-1:0] out_col;
   logic [PIX_W-1:0]     out_value;
   logic                 last;
   logic                 frame_done;
   modport source (output valid, output out_row, output out_col, output out_value,
                   output last, output frame_done, input ready);
   modport sink (input valid, input out_row, input out_col, input out_value,
                 input last, input frame_done, output ready);
endinterface

interface meaf_csr_if import meaf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/mask_edge_antialias_filter_unit.sv
// Top level of the mask edge antialias filter: front end, beat queue and back end.
//
//  channel   dir  beat contents
//  --------  ---  ----------------------------------------------------------
//  req_chan  in   pixel: next frame pixel in raster order
//  rsp_chan  out  out_row, out_col, out_value, last, frame_done
//  csr_chan  in   index (0 frame_width, 1 frame_height), data
//
//  One pixel beat per clock is taken while the queue has room; row r goes out
//  while row r+1 comes in, one result per clock while rsp_chan is ready, from a
//  single output register. Final-row pixels give two results each when a row
//  above exists, so the output register sets the pace there, the four-entry
//  queue soaking up bursts. Synchronous reset clears control state only; the
//  line buffers need no clear since every entry is written before it is read.
//  A write to frame_width or frame_height restarts the frame position, and
//  writes are taken on any cycle (csr_chan.ready is tied high).
module mask_edge_antialias_filter_unit import meaf_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   meaf_req_if.sink    req_chan,
   meaf_rsp_if.source  rsp_chan,
   meaf_csr_if.sink    csr_chan
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int FLG_W = $bits(meaf_flags_type);
   localparam int QW    = PIX_W + ROW_W + 2 * COL_W + FLG_W;

   logic             push_valid, push_ready, pop_valid, pop_ready;
   logic [PIX_W-1:0] push_pixel, pop_pixel;
   logic [ROW_W-1:0] push_row, pop_row;
   logic [COL_W-1:0] push_col, push_nxt_col, pop_col, pop_nxt_col;
   meaf_flags_type   push_flags, pop_flags;
   logic [QW-1:0]    push_data, pop_data;

   meaf_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .csr_chan     (csr_chan),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_pixel   (push_pixel),
      .push_row     (push_row),
      .push_col     (push_col),
      .push_nxt_col (push_nxt_col),
      .push_flags   (push_flags)
   );

   assign push_data = {push_pixel, push_row, push_col, push_nxt_col, push_flags};

   // decouples pixel intake from result stalls
   meaf_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {pop_pixel, pop_row, pop_col, pop_nxt_col, pop_flags} = pop_data;

   meaf_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_pixel   (pop_pixel),
      .pop_row     (pop_row),
      .pop_col     (pop_col),
      .pop_nxt_col (pop_nxt_col),
      .pop_flags   (pop_flags),
      .rsp_chan    (rsp_chan)
   );

endmodule

>>> src/meaf_queue.sv
// Small first-in first-out queue between the front end and the filter back end.
module meaf_queue import meaf_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/meaf_front.sv
// Front end: register port, raster position counters and per-beat classification.
module meaf_front import meaf_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int COL_W = $clog2(DEF_MAX_WIDTH)
) (
   input  logic             clock,
   input  logic             reset,
   meaf_req_if.sink         req_chan,
   meaf_csr_if.sink         csr_chan,
   output logic             push_valid,
   input  logic             push_ready,
   output logic [PIX_W-1:0] push_pixel,
   output logic [ROW_W-1:0] push_row,
   output logic [COL_W-1:0] push_col,
   output logic [COL_W-1:0] push_nxt_col,
   output meaf_flags_type   push_flags
);

   logic [FW_W-1:0]  fw_ff, fw_in;
   logic [ROW_W-1:0] fh_ff, fh_in;
   logic [ROW_W-1:0] row_ff, row_in, h_last;
   logic [COL_W-1:0] col_ff, col_in, w_last;
   logic             accept, csr_fire, restart, at_row_end, last_row, end_frame;

   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid;

   // Effective width: zero acts as one, oversize clamps to the line buffer.
   always_comb begin
      if (fw_ff == '0) begin
         w_last = '0;
      end else if (32'(fw_ff) > 32'(MAX_WIDTH)) begin
         w_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_last = COL_W'(fw_ff - FW_W'(1));
      end
   end

   assign h_last = (fh_ff == '0) ? '0 : fh_ff - ROW_W'(1);

   assign accept          = req_chan.valid && push_ready;
   assign req_chan.ready  = push_ready;
   assign push_valid      = req_chan.valid;
   assign push_pixel      = req_chan.pixel;
   assign push_row        = row_ff;
   assign push_col        = col_ff;

   assign at_row_end = (col_ff == w_last);
   assign last_row   = (row_ff == h_last);
   assign end_frame  = last_row && at_row_end;

   assign push_nxt_col         = at_row_end ? '0 : col_ff + COL_W'(1);
   assign push_flags.has_up    = (row_ff != '0);
   assign push_flags.last_row  = last_row;
   assign push_flags.end_frame = end_frame;
   assign push_flags.filt_ok   = (row_ff >= ROW_W'(2)) && (col_ff != '0) && (col_ff < w_last);
   assign push_flags.self_wrap = (w_last == '0);

   always_comb begin
      fw_in   = fw_ff;
      fh_in   = fh_ff;
      restart = 1'b0;
      if (csr_fire) begin
         case (csr_chan.index)
            REG_FRAME_WIDTH: begin
               fw_in   = csr_chan.data[FW_W-1:0];
               restart = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               fh_in   = csr_chan.data[ROW_W-1:0];
               restart = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (end_frame) begin
            row_in = '0;
            col_in = '0;
         end else if (at_row_end) begin
            row_in = row_ff + ROW_W'(1);
            col_in = '0;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff  <= FW_RESET;
         fh_ff  <= FH_RESET;
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         fw_ff  <= fw_in;
         fh_ff  <= fh_in;
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

>>> src/meaf_back.sv
// Back end: line buffers, neighbour count, write-back and result register.
module meaf_back import meaf_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int COL_W = $clog2(DEF_MAX_WIDTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  logic [PIX_W-1:0] pop_pixel,
   input  logic [ROW_W-1:0] pop_row,
   input  logic [COL_W-1:0] pop_col,
   input  logic [COL_W-1:0] pop_nxt_col,
   input  meaf_flags_type   pop_flags,
   meaf_rsp_if.source       rsp_chan
);

   // line buffers: original pixels of the row above, and "final value was full"
   logic [PIX_W-1:0] prev_mem [MAX_WIDTH];
   logic             up_mem   [MAX_WIDTH];

   logic                 b_valid_ff, b_valid_in;
   logic                 b_phase_ff, b_phase_in;
   logic [PIX_W-1:0]     b_pixel_ff;
   logic [ROW_W-1:0]     b_row_ff;
   logic [COL_W-1:0]     b_col_ff;
   meaf_flags_type       b_flags_ff;
   logic [PIX_W-1:0]     rd_prev_ff;  // right neighbour, original
   logic                 rd_up_ff;    // upper neighbour, final
   logic [PIX_W-1:0]     hold_ff;     // this column's original, from the last lookahead
   logic                 left_full_ff;

   logic                 out_valid_ff, out_valid_in;
   logic [ROW_W-1:0]     out_row_ff;
   logic [COL_OUT_W-1:0] out_col_ff;
   logic [PIX_W-1:0]     out_value_ff;
   logic                 out_last_ff, out_done_ff;

   logic             pop, two, needs_out, out_free, b_step, b_done, wr_en, up_result;
   logic [2:0]       cnt;
   logic [PIX_W-1:0] val, next_orig;

   assign two       = b_flags_ff.has_up && b_flags_ff.last_row;
   assign needs_out = b_phase_ff || b_flags_ff.has_up || b_flags_ff.last_row;
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign b_step    = b_valid_ff && (!needs_out || out_free);
   assign b_done    = b_step && (b_phase_ff || !two);
   assign pop_ready = !b_valid_ff || b_done;
   assign pop       = pop_valid && pop_ready;
   assign wr_en     = b_step && !b_phase_ff;
   assign up_result = !b_phase_ff && b_flags_ff.has_up;

   assign cnt = 3'(left_full_ff) + 3'(rd_up_ff) + 3'(rd_prev_ff == FULL_LEVEL)
              + 3'(b_pixel_ff == FULL_LEVEL);
   assign val = (b_flags_ff.filt_ok && hold_ff == '0) ? fill_level(cnt) : hold_ff;
   assign next_orig = b_flags_ff.self_wrap ? b_pixel_ff : rd_prev_ff;

   always_comb begin
      b_valid_in = b_valid_ff;
      if (pop) begin
         b_valid_in = 1'b1;
      end else if (b_done) begin
         b_valid_in = 1'b0;
      end
      b_phase_in = b_phase_ff;
      if (b_step) begin
         b_phase_in = !b_phase_ff && two;
      end
      out_valid_in = out_valid_ff;
      if (b_step && needs_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         b_phase_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         left_full_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         b_phase_ff   <= b_phase_in;
         out_valid_ff <= out_valid_in;
         if (wr_en && b_flags_ff.has_up) begin
            left_full_ff <= (val == FULL_LEVEL);
         end
      end
   end

   // stage load and lookahead reads; forward a same-cycle write to the read
   always_ff @(posedge clock) begin
      if (pop) begin
         b_pixel_ff <= pop_pixel;
         b_row_ff   <= pop_row;
         b_col_ff   <= pop_col;
         b_flags_ff <= pop_flags;
         rd_up_ff   <= up_mem[pop_col];
         if (wr_en && b_col_ff == pop_nxt_col) begin
            rd_prev_ff <= b_pixel_ff;
         end else begin
            rd_prev_ff <= prev_mem[pop_nxt_col];
         end
      end
      if (wr_en) begin
         hold_ff <= next_orig;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prev_mem[b_col_ff] <= b_pixel_ff;
         if (b_flags_ff.has_up) begin
            up_mem[b_col_ff] <= (val == FULL_LEVEL);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_step && needs_out) begin
         out_col_ff <= COL_OUT_W'(b_col_ff);
         if (up_result) begin
            out_row_ff   <= b_row_ff - ROW_W'(1);
            out_value_ff <= val;
            out_last_ff  <= !two;
            out_done_ff  <= b_flags_ff.end_frame && !two;
         end else begin
            out_row_ff   <= b_row_ff;
            out_value_ff <= b_pixel_ff;
            out_last_ff  <= 1'b1;
            out_done_ff  <= b_flags_ff.end_frame;
         end
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.out_row    = out_row_ff;
   assign rsp_chan.out_col    = out_col_ff;
   assign rsp_chan.out_value  = out_value_ff;
   assign rsp_chan.last       = out_last_ff;
   assign rsp_chan.frame_done = out_done_ff;

endmodule
